>>> hdl/bwtf_pkg.sv
// ----------------------------------------------------------------------------
// bwtf_pkg
// shared widths, status codes and controller/datapath command types
// ----------------------------------------------------------------------------
package bwtf_pkg;

    localparam int unsigned BLOCK_BYTES_DEF = 1024;

    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_CLOSE  = 2'd1;
    localparam logic [1:0] ACT_FETCH  = 2'd2;

    localparam logic [1:0] ST_SYMBOL  = 2'd0;
    localparam logic [1:0] ST_CLOSED  = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam int unsigned LEN_W = 11;

    // controller to datapath commands
    typedef struct packed {
        logic append;      // write in_byte at count
        logic new_block;   // clear count and dropped before append
        logic init_wr;     // write order[k] = k
        logic cmp_load;    // start compare of rotations a and b
        logic cmp_step;    // compare in progress; the datapath steps on its own
        logic out_wr;      // write merged entry to output bank
        logic out_sel_q;   // merged entry comes from q
        logic bank_flip;   // swap banks after a pass
        logic fetch_rd;    // issue read of order[fetch pointer]
        logic sym_rd;      // issue text read for fetched start
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic cmp_done;
        logic cmp_less;    // rotation q sorts below rotation p
    } t_sts;

endpackage

>>> hdl/bwtf_if.sv
// ----------------------------------------------------------------------------
// bwtf_in_if / bwtf_out_if
// valid/ready channels for action items and result items
// ----------------------------------------------------------------------------
interface bwtf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] in_byte;
    modport source (output valid, action, in_byte, input ready);
    modport sink   (input valid, action, in_byte, output ready);
endinterface

interface bwtf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        is_marker;
    logic        is_final;
    logic [1:0]  status;
    logic [10:0] block_length;
    modport source (output valid, out_byte, is_marker, is_final, status, block_length,
                    input ready);
    modport sink   (input valid, out_byte, is_marker, is_final, status, block_length,
                    output ready);
endinterface

>>> hdl/bwtf_datapath.sv
// ----------------------------------------------------------------------------
// bwtf_datapath
// text store, two order banks and the byte-serial rotation comparator
// ----------------------------------------------------------------------------
module bwtf_datapath #(
    parameter int unsigned BLOCK_BYTES = bwtf_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned IW = $clog2(BLOCK_BYTES + 2)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bwtf_pkg::t_cmd   i_cmd,
    input  logic [7:0]       i_byte,
    input  logic [IW-1:0]    i_idx_a,   // order read address p (or fetch ptr)
    input  logic [IW-1:0]    i_idx_b,   // order read address q
    input  logic [IW-1:0]    i_idx_w,   // write address for init / merge out
    output bwtf_pkg::t_sts   o_sts,
    output logic [IW-1:0]    o_count,
    output logic             o_dropped,
    output logic [IW-1:0]    o_start,   // registered order read (port a)
    output logic [7:0]       o_sym
);
    localparam int unsigned TW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int unsigned ND = BLOCK_BYTES + 1;

    logic [7:0]    r_text [BLOCK_BYTES];
    logic [IW-1:0] r_ord0 [ND];
    logic [IW-1:0] r_ord1 [ND];
    logic          r_bank;
    logic [IW-1:0] r_count;
    logic          r_dropped;
    logic [IW-1:0] r_ra0, r_rb0, r_ra1, r_rb1;
    logic [IW-1:0] w_ra, w_rb;

    // compare state
    logic [IW-1:0] r_ca, r_cb;
    logic [7:0]    r_ta;
    logic          r_tv;          // text read address on r_cb instead of r_ca
    logic          r_cdone, r_cless, r_busy;
    logic [IW-1:0] n_ca, n_cb;

    // order banks: read both, write into the other
    always_ff @(posedge i_clk) begin
        r_ra0 <= r_ord0[i_idx_a];
        r_rb0 <= r_ord0[i_idx_b];
        r_ra1 <= r_ord1[i_idx_a];
        r_rb1 <= r_ord1[i_idx_b];
        if (i_cmd.init_wr) begin
            r_ord0[i_idx_w] <= i_idx_w;
        end else if (i_cmd.out_wr && !r_bank) begin
            r_ord1[i_idx_w] <= i_cmd.out_sel_q ? w_rb : w_ra;
        end else if (i_cmd.out_wr && r_bank) begin
            r_ord0[i_idx_w] <= i_cmd.out_sel_q ? w_rb : w_ra;
        end
    end
    assign w_ra = r_bank ? r_ra1 : r_ra0;
    assign w_rb = r_bank ? r_rb1 : r_rb0;
    assign o_start = w_ra;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
        end else if (i_cmd.init_wr) begin
            r_bank <= 1'b0;
        end else if (i_cmd.bank_flip) begin
            r_bank <= ~r_bank;
        end
    end

    // byte count and drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.append) begin
            if (i_cmd.new_block || r_count < IW'(BLOCK_BYTES)) begin
                r_count   <= i_cmd.new_block ? IW'(1) : r_count + IW'(1);
                r_dropped <= i_cmd.new_block ? 1'b0 : r_dropped;
            end else begin
                r_dropped <= 1'b1;
            end
        end
    end
    assign o_count   = r_count;
    assign o_dropped = r_dropped;

    // text store: one write port, one registered read port
    logic [IW-1:0] w_taddr;
    logic [7:0]    r_trd;
    always_comb begin
        if (i_cmd.sym_rd) begin
            w_taddr = w_ra - IW'(1);
        end else begin
            w_taddr = r_tv ? r_cb : r_ca;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && (i_cmd.new_block || r_count < IW'(BLOCK_BYTES))) begin
            r_text[TW'(i_cmd.new_block ? '0 : r_count)] <= i_byte;
        end
        r_trd <= r_text[TW'(w_taddr)];
    end
    assign o_sym = r_trd;

    // serial compare: read a byte, then b byte, then decide (phases C_RA, C_RB, C_EV)
    typedef enum logic [1:0] {C_RA, C_RB, C_EV} t_cph;
    t_cph r_cph;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cdone <= 1'b0;
            r_cless <= 1'b0;
            r_tv    <= 1'b0;
            r_cph   <= C_RA;
        end else begin
            r_cdone <= 1'b0;
            if (i_cmd.cmp_load) begin
                r_ca   <= w_rb;   // a = q, b = p: less means q below p
                r_cb   <= w_ra;
                r_busy <= 1'b1;
                r_tv   <= 1'b0;
                r_cph  <= C_RA;
            end else if (r_busy) begin
                unique case (r_cph)
                    C_RA: begin
                        if (r_ca == r_cb) begin
                            r_cless <= 1'b0; r_cdone <= 1'b1; r_busy <= 1'b0;
                        end else if (r_ca >= r_count) begin
                            r_cless <= 1'b1; r_cdone <= 1'b1; r_busy <= 1'b0;
                        end else if (r_cb >= r_count) begin
                            r_cless <= 1'b0; r_cdone <= 1'b1; r_busy <= 1'b0;
                        end else begin
                            r_tv  <= 1'b1;   // read of a issued this cycle
                            r_cph <= C_RB;
                        end
                    end
                    C_RB: begin
                        r_ta  <= r_trd;
                        r_tv  <= 1'b0;
                        r_cph <= C_EV;
                    end
                    C_EV: begin
                        if (r_ta != r_trd) begin
                            r_cless <= r_ta < r_trd; r_cdone <= 1'b1; r_busy <= 1'b0;
                        end else begin
                            r_ca <= n_ca; r_cb <= n_cb;
                        end
                        r_cph <= C_RA;
                    end
                    default: r_cph <= C_RA;
                endcase
            end
        end
    end
    assign n_ca = r_ca + IW'(1);
    assign n_cb = r_cb + IW'(1);
    assign o_sts = '{cmp_done: r_cdone, cmp_less: r_cless};
endmodule

>>> hdl/bwtf_ctrl.sv
// ----------------------------------------------------------------------------
// bwtf_ctrl
// sequencer: item decode, bottom-up merge sort passes, fetch and result
// ----------------------------------------------------------------------------
module bwtf_ctrl #(
    parameter int unsigned BLOCK_BYTES = bwtf_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned IW = $clog2(BLOCK_BYTES + 2)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_action,
    output logic             o_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_is_marker,
    output logic             o_is_final,
    output logic [1:0]       o_status,
    output logic [10:0]      o_block_length,
    output bwtf_pkg::t_cmd   o_cmd,
    output logic [IW-1:0]    o_idx_a,
    output logic [IW-1:0]    o_idx_b,
    output logic [IW-1:0]    o_idx_w,
    input  bwtf_pkg::t_sts   i_sts,
    input  logic [IW-1:0]    i_count,
    input  logic             i_dropped,
    input  logic [IW-1:0]    i_start,
    input  logic [7:0]       i_sym
);
    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_PASS, S_MRD, S_MWT, S_MCMP, S_MWR, S_FRD, S_FWT, S_FSYM, S_FOUT
    } t_state;

    t_state        r_state;
    logic          r_sorted;
    logic [IW-1:0] r_fptr, r_total, r_k, r_w, r_lo, r_mid, r_hi, r_p, r_q;
    logic          r_ovalid;
    logic [7:0]    r_obyte;
    logic          r_omark, r_ofin;
    logic [1:0]    r_ostat;
    logic [10:0]   r_olen;
    logic          r_selq, r_mark;
    logic          w_oset;
    logic          w_fetch_ph;

    wire w_take = i_valid && o_ready;
    wire w_out_free = !r_ovalid || i_out_ready;
    assign o_ready = (r_state == S_IDLE) && w_out_free;

    // a result is loaded: empty fetch, end of sort, or fetched symbol
    assign w_oset = ((r_state == S_IDLE) && w_take && (i_action == bwtf_pkg::ACT_FETCH)
                     && (!r_sorted || r_fptr >= i_count + IW'(1)))
                    || ((r_state == S_PASS) && (r_w >= r_total))
                    || (r_state == S_FOUT);

    // order read stays on the fetch pointer until the symbol is read
    assign w_fetch_ph = (r_state == S_FRD) || (r_state == S_FWT) || (r_state == S_FSYM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_oset) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sorted <= 1'b0;
            r_fptr   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        if (i_action == bwtf_pkg::ACT_APPEND) begin
                            if (r_sorted) begin
                                r_sorted <= 1'b0;
                                r_fptr   <= '0;
                            end
                        end else if (i_action == bwtf_pkg::ACT_CLOSE) begin
                            r_total <= i_count + IW'(1);
                            r_k     <= '0;
                            r_state <= S_INIT;
                        end else if (i_action == bwtf_pkg::ACT_FETCH) begin
                            if (!r_sorted || r_fptr >= i_count + IW'(1)) begin
                                r_obyte <= '0; r_omark <= 1'b0; r_ofin <= 1'b0;
                                r_ostat <= bwtf_pkg::ST_EMPTY; r_olen <= '0;
                            end else begin
                                r_state <= S_FRD;
                            end
                        end
                    end
                end
                S_INIT: begin
                    if (r_k == r_total - IW'(1)) begin
                        r_w <= IW'(1);
                        r_state <= S_PASS;
                    end
                    r_k <= r_k + IW'(1);
                end
                S_PASS: begin
                    // start of a pass (r_lo = 0), or end of the sort once the width covers the block
                    if (r_w >= r_total) begin
                        r_sorted <= 1'b1;
                        r_fptr   <= '0;
                        r_obyte <= '0; r_omark <= 1'b0; r_ofin <= 1'b0;
                        r_ostat <= i_dropped ? bwtf_pkg::ST_DROPPED : bwtf_pkg::ST_CLOSED;
                        r_olen  <= 11'(r_total);
                        r_state <= S_IDLE;
                    end else begin
                        r_lo <= '0; r_k <= '0; r_p <= '0;
                        r_mid <= (r_w > r_total) ? r_total : r_w;
                        r_q   <= (r_w > r_total) ? r_total : r_w;
                        r_hi  <= ({1'b0, r_w, 1'b0} > {2'b0, r_total}) ? r_total
                                 : IW'({r_w, 1'b0});
                        r_state <= S_MRD;
                    end
                end
                S_MRD: begin
                    if (r_lo >= r_total) begin
                        // width doubles, saturating at all ones when the doubling would overflow
                        r_w <= r_w[IW-1] ? '1 : {r_w[IW-2:0], 1'b0};
                        r_state <= S_PASS;
                    end else if (r_p < r_mid && r_q < r_hi) begin
                        r_state <= S_MWT;
                    end else if (r_p < r_mid || r_q < r_hi) begin
                        r_selq  <= !(r_p < r_mid);
                        r_state <= S_MWT;
                    end else begin
                        // next window
                        r_lo  <= r_hi;
                        r_p   <= r_hi;
                        r_mid <= (({1'b0, r_hi} + {1'b0, r_w}) > {1'b0, r_total})
                                 ? r_total : IW'(r_hi + r_w);
                        r_q   <= (({1'b0, r_hi} + {1'b0, r_w}) > {1'b0, r_total})
                                 ? r_total : IW'(r_hi + r_w);
                        r_hi  <= (({1'b0, r_hi} + {r_w, 1'b0}) > {1'b0, r_total})
                                 ? r_total : IW'(r_hi + {r_w[IW-2:0], 1'b0});
                    end
                end
                S_MWT: begin
                    // read data now registered
                    r_state <= (r_p < r_mid && r_q < r_hi) ? S_MCMP : S_MWR;
                end
                S_MCMP: begin
                    if (i_sts.cmp_done) begin
                        r_selq  <= i_sts.cmp_less;
                        r_state <= S_MWR;
                    end
                end
                S_MWR: begin
                    if (r_selq) r_q <= r_q + IW'(1);
                    else        r_p <= r_p + IW'(1);
                    r_k <= r_k + IW'(1);
                    r_state <= S_MRD;
                end
                S_FRD: r_state <= S_FWT;
                S_FWT: begin
                    r_mark  <= (i_start == '0) || (i_start > i_count);
                    r_state <= S_FSYM;
                end
                S_FSYM: r_state <= S_FOUT;
                S_FOUT: begin
                    r_obyte  <= r_mark ? 8'd0 : i_sym;
                    r_omark  <= r_mark;
                    r_ofin   <= (r_fptr + IW'(1)) == (i_count + IW'(1));
                    r_ostat  <= bwtf_pkg::ST_SYMBOL;
                    r_olen   <= '0;
                    r_fptr   <= r_fptr + IW'(1);
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath commands
    always_comb begin
        o_cmd = '0;
        o_cmd.append    = w_take && (i_action == bwtf_pkg::ACT_APPEND);
        o_cmd.new_block = r_sorted;
        o_cmd.init_wr   = (r_state == S_INIT);
        o_cmd.cmp_load  = (r_state == S_MWT) && (r_p < r_mid) && (r_q < r_hi);
        o_cmd.out_wr    = (r_state == S_MWR);
        o_cmd.out_sel_q = r_selq;
        o_cmd.bank_flip = (r_state == S_MRD) && (r_lo >= r_total);
        o_cmd.sym_rd    = (r_state == S_FWT) || (r_state == S_FSYM);
        o_cmd.fetch_rd  = (r_state == S_FRD);
        o_cmd.cmp_step  = (r_state == S_MCMP);
        o_idx_a = w_fetch_ph ? r_fptr : r_p;
        o_idx_b = r_q;
        o_idx_w = r_k;
    end

    assign o_valid        = r_ovalid;
    assign o_out_byte     = r_obyte;
    assign o_is_marker    = r_omark;
    assign o_is_final     = r_ofin;
    assign o_status       = r_ostat;
    assign o_block_length = r_olen;
endmodule

>>> hdl/bwt_forward_block.sv
// ----------------------------------------------------------------------------
// bwt_forward_block
// forward burrows-wheeler transform of a byte block with an end marker
// ----------------------------------------------------------------------------
// usage:
//   i_in carries action items (append, close, fetch); o_out carries results
//   append: one transfer per cycle while idle and the result slot is free; no
//     result; a full store drops the byte
//   close: seeds the order, then merge sorts the n+1 rotations, then one
//     result with the length and the closed or dropped status; the sort runs
//     ceil(log2(n+1)) passes, each writing n+1 entries, at most one compare
//     per merged entry; a compare walks the text one byte at a time through
//     the single text read port, reading the a byte, then the b byte, then
//     deciding before it steps to the next byte pair
//   fetch: the result passes through the order read, the text read and the
//     output register; no further item is taken until that result is loaded
//   action 3 is taken and dropped
//   reset: count, drop flag, sort flag and fetch pointer clear; the stores
//     hold garbage and are only read where written
//   a stalled receiver holds the output register; the next item is taken
//   only once the result slot frees
// ----------------------------------------------------------------------------
module bwt_forward_block #(
    parameter int unsigned BLOCK_BYTES = bwtf_pkg::BLOCK_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bwtf_in_if.sink    i_in,
    bwtf_out_if.source o_out
);
    localparam int unsigned IW = $clog2(BLOCK_BYTES + 2);

    bwtf_pkg::t_cmd w_cmd;
    bwtf_pkg::t_sts w_sts;
    logic [IW-1:0]  w_ia, w_ib, w_iw, w_count, w_start;
    logic           w_dropped;
    logic [7:0]     w_sym;

    // sequencer and result register
    bwtf_ctrl #(.BLOCK_BYTES(BLOCK_BYTES), .IW(IW)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_valid(i_in.valid), .o_ready(i_in.ready), .i_action(i_in.action),
        .o_valid(o_out.valid), .i_out_ready(o_out.ready),
        .o_out_byte(o_out.out_byte), .o_is_marker(o_out.is_marker),
        .o_is_final(o_out.is_final), .o_status(o_out.status),
        .o_block_length(o_out.block_length),
        .o_cmd(w_cmd), .o_idx_a(w_ia), .o_idx_b(w_ib), .o_idx_w(w_iw),
        .i_sts(w_sts), .i_count(w_count), .i_dropped(w_dropped),
        .i_start(w_start), .i_sym(w_sym)
    );

    // stores and comparator
    bwtf_datapath #(.BLOCK_BYTES(BLOCK_BYTES), .IW(IW)) u_dp (
        .i_clk, .i_rst_n,
        .i_cmd(w_cmd), .i_byte(i_in.in_byte),
        .i_idx_a(w_ia), .i_idx_b(w_ib), .i_idx_w(w_iw),
        .o_sts(w_sts), .o_count(w_count), .o_dropped(w_dropped),
        .o_start(w_start), .o_sym(w_sym)
    );
endmodule
